>>> hw/rtl/mgsm_pkg.sv
`timescale 1ns / 1ps
package mgsm_pkg;

   // Character and pattern geometry
   localparam int unsigned CHAR_W           = 16;
   localparam int unsigned PATTERN_CAPACITY = 64;

   // Special character codes
   localparam logic [CHAR_W-1:0] SPACE_CODE = CHAR_W'(16'h0020);
   localparam logic [CHAR_W-1:0] STAR_CODE  = CHAR_W'(16'h002A);
   localparam logic [CHAR_W-1:0] QMARK_CODE = CHAR_W'(16'h003F);
   localparam logic [CHAR_W-1:0] UPPER_A    = CHAR_W'(16'h0041);
   localparam logic [CHAR_W-1:0] UPPER_Z    = CHAR_W'(16'h005A);
   localparam logic [CHAR_W-1:0] CASE_DIFF  = CHAR_W'(16'h0020);

   // Register indexes
   typedef enum logic [0:0] {
      CSR_MATCH_MODE     = 1'b0,
      CSR_CASE_SENSITIVE = 1'b1
   } csr_index_type;

   // Item kinds
   localparam logic FUNC_PATTERN   = 1'b0;
   localparam logic FUNC_CANDIDATE = 1'b1;

   // Broadcast control from the top level to every cell
   typedef struct packed {
      logic load_clear;
      logic wr_en;
      logic is_space;
      logic is_glob_char;
      logic word_glob;
      logic cand_en;
      logic start;
      logic step;
      logic mode;
      logic fold;
   } ctl_type;

   // Signals handed from one cell to its right neighbor
   typedef struct packed {
      logic bound;
      logic carry;
      logic init_carry;
   } link_type;

   // Fold ASCII upper case to lower case when enabled
   function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                   input logic en);
      if (en && c >= UPPER_A && c <= UPPER_Z) begin
         return c + CASE_DIFF;
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/mgsm_if.sv
`timescale 1ns / 1ps
interface mgsm_req_if;
   logic                       valid;
   logic                       ready;
   logic                       func;
   logic [mgsm_pkg::CHAR_W-1:0] ch;
   logic                       has_char;
   logic                       last;
   modport source (output valid, func, ch, has_char, last, input ready);
   modport sink (input valid, func, ch, has_char, last, output ready);
endinterface

interface mgsm_rsp_if;
   logic valid;
   logic ready;
   logic matched;
   logic pattern_truncated;
   modport source (output valid, matched, pattern_truncated, input ready);
   modport sink (input valid, matched, pattern_truncated, output ready);
endinterface

interface mgsm_csr_if;
   logic valid;
   logic ready;
   logic index;
   logic data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/mgsm_cell.sv
`timescale 1ns / 1ps
module mgsm_cell #(
   parameter int unsigned IDX   = 0,
   parameter int unsigned LEN_W = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mgsm_pkg::ctl_type           ctl,
   input  logic [LEN_W-1:0]            wr_idx,
   input  logic [mgsm_pkg::CHAR_W-1:0] wr_ch,
   input  logic [mgsm_pkg::CHAR_W-1:0] cand_ch,
   input  mgsm_pkg::link_type          left,
   input  logic                        right_bound,
   output mgsm_pkg::link_type          link_out,
   output logic                        ok
);

   logic [mgsm_pkg::CHAR_W-1:0] ch_ff;
   logic valid_ff, valid_in;
   logic sp_ff, sp_in;
   logic gl_ff, gl_in;
   logic cw_ff, cw_in;
   logic act_ff, act_in;
   logic endact_ff, endact_in;
   logic sat_ff, sat_in;

   logic wr_sel, in_word, ws, g, is_star, is_q, last_pos;
   logic init, init_cout, acur, m, stay, nx, cout, end_cur, sat_cur;

   assign wr_sel = ctl.wr_en && (wr_idx == LEN_W'(IDX));

   // Pattern load: store the character and track word membership
   always_comb begin
      valid_in = valid_ff;
      sp_in    = sp_ff;
      gl_in    = gl_ff;
      cw_in    = cw_ff;
      if (ctl.load_clear) begin
         valid_in = 1'b0;
         cw_in    = 1'b0;
      end
      if (wr_sel) begin
         valid_in = 1'b1;
         sp_in    = ctl.is_space;
         gl_in    = !ctl.is_space && (ctl.word_glob || ctl.is_glob_char);
         cw_in    = !ctl.is_space;
      end else if (ctl.wr_en && !ctl.load_clear) begin
         if (ctl.is_space) begin
            cw_in = 1'b0;
         end else if (ctl.is_glob_char && cw_ff) begin
            gl_in = 1'b1;
         end
      end
   end

   // Candidate step: advance the active bit along the word
   assign in_word  = valid_ff && !sp_ff;
   assign ws       = in_word && left.bound;
   assign g        = ctl.mode && gl_ff;
   assign is_star  = ch_ff == mgsm_pkg::STAR_CODE;
   assign is_q     = ch_ff == mgsm_pkg::QMARK_CODE;
   assign last_pos = in_word && right_bound;

   always_comb begin
      init      = in_word && (ws || (g && left.init_carry));
      init_cout = in_word && g && init && is_star;
      acur      = ctl.start ? init : act_ff;
      m         = acur && ((g && is_q) || (!(g && is_star) &&
                  mgsm_pkg::fold_char(ch_ff, ctl.fold) == cand_ch));
      stay      = acur && g && is_star;
      nx        = in_word && ((!ws && left.carry) || stay || (!g && ws));
      cout      = in_word && (m || (g && nx && is_star));
      end_cur   = ctl.start ? init_cout : endact_ff;
      sat_cur   = ctl.start ? 1'b0 : sat_ff;
      if (ctl.step) begin
         act_in    = nx;
         endact_in = cout;
         sat_in    = sat_cur || (!g && cout);
      end else begin
         act_in    = acur;
         endact_in = end_cur;
         sat_in    = sat_cur;
      end
   end

   assign ok                  = !last_pos || (g ? endact_in : sat_in);
   assign link_out.bound      = !valid_ff || sp_ff;
   assign link_out.carry      = cout;
   assign link_out.init_carry = init_cout;

   // Hold the pattern character
   always_ff @(posedge clock) begin
      if (wr_sel) begin
         ch_ff <= wr_ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         sp_ff     <= 1'b0;
         gl_ff     <= 1'b0;
         cw_ff     <= 1'b0;
         act_ff    <= 1'b0;
         endact_ff <= 1'b0;
         sat_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sp_ff    <= sp_in;
         gl_ff    <= gl_in;
         cw_ff    <= cw_in;
         if (ctl.cand_en) begin
            act_ff    <= act_in;
            endact_ff <= endact_in;
            sat_ff    <= sat_in;
         end
      end
   end

endmodule

>>> hw/rtl/multiword_glob_substring_matcher.sv
`timescale 1ns / 1ps
// Channel   Dir  Fields                         Word accepted when
// req_bus   in   func, ch, has_char, last       valid && ready
// rsp_bus   out  matched, pattern_truncated     valid && ready
// csr_bus   in   index, data                    valid && ready (always ready)
//
// One word is taken per cycle while the input is ready; a candidate character steps
// every pattern cell at once, so the rate is one word per clock when not stalled.
// The result enters a registered two-entry output stage on the final candidate
// word; input stalls only when both entries are full.
// Synchronous reset clears the pattern, flags and control registers; no clearing pass.
module multiword_glob_substring_matcher #(
   parameter int unsigned PATTERN_CAPACITY = mgsm_pkg::PATTERN_CAPACITY
) (
   input logic       clock,
   input logic       reset,
   mgsm_req_if.sink   req_bus,
   mgsm_rsp_if.source rsp_bus,
   mgsm_csr_if.sink   csr_bus
);

   localparam int unsigned LEN_W = $clog2(PATTERN_CAPACITY + 1);

   logic mode_ff, mode_in, case_ff, case_in;
   logic [LEN_W-1:0] len_ff, len_in, eff_len;
   logic trunc_ff, trunc_in, loading_ff, loading_in, cand_ff, cand_in;
   logic wg_ff, wg_in;
   logic head_v_ff, head_v_in, skid_v_ff, skid_v_in;
   logic [1:0] head_ff, head_in, skid_ff, skid_in;

   logic req_fire, pat_fire, cand_fire, res_new, pop;
   logic [1:0] res;
   logic [mgsm_pkg::CHAR_W-1:0] cf;
   mgsm_pkg::ctl_type ctl;
   mgsm_pkg::link_type links [PATTERN_CAPACITY+1];
   logic [PATTERN_CAPACITY-1:0] ok_vec;

   assign req_bus.ready = !skid_v_ff;
   assign csr_bus.ready = 1'b1;
   assign req_fire  = req_bus.valid && req_bus.ready;
   assign pat_fire  = req_fire && (req_bus.func == mgsm_pkg::FUNC_PATTERN);
   assign cand_fire = req_fire && (req_bus.func == mgsm_pkg::FUNC_CANDIDATE);

   // Broadcast control to the cell row
   always_comb begin
      ctl.load_clear   = pat_fire && !loading_ff;
      eff_len          = ctl.load_clear ? '0 : len_ff;
      ctl.wr_en        = pat_fire && req_bus.has_char &&
                         (eff_len < LEN_W'(PATTERN_CAPACITY));
      ctl.is_space     = req_bus.ch == mgsm_pkg::SPACE_CODE;
      ctl.is_glob_char = (req_bus.ch == mgsm_pkg::STAR_CODE) ||
                         (req_bus.ch == mgsm_pkg::QMARK_CODE);
      ctl.word_glob    = ctl.load_clear ? 1'b0 : wg_ff;
      ctl.cand_en      = cand_fire;
      ctl.start        = !cand_ff;
      ctl.step         = req_bus.has_char;
      ctl.mode         = mode_ff;
      ctl.fold         = !mode_ff || !case_ff;
   end

   assign cf = mgsm_pkg::fold_char(req_bus.ch, ctl.fold);

   // Row of pattern cells
   assign links[0] = '{bound: 1'b1, carry: 1'b0, init_carry: 1'b0};

   for (genvar i = 0; i < PATTERN_CAPACITY; i++) begin : g_cell
      logic rb;
      // Boundary flag of the right neighbor of this cell
      if (i == PATTERN_CAPACITY - 1) begin : g_end
         assign rb = 1'b1;
      end else begin : g_mid
         assign rb = links[i+2].bound;
      end
      mgsm_cell #(.IDX(i), .LEN_W(LEN_W)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .wr_idx     (eff_len),
         .wr_ch      (req_bus.ch),
         .cand_ch    (cf),
         .left       (links[i]),
         .right_bound(rb),
         .link_out   (links[i+1]),
         .ok         (ok_vec[i])
      );
   end

   // Load and candidate sequencing
   always_comb begin
      len_in     = len_ff;
      trunc_in   = trunc_ff;
      wg_in      = wg_ff;
      loading_in = loading_ff;
      cand_in    = cand_ff;
      if (pat_fire) begin
         len_in     = ctl.wr_en ? eff_len + LEN_W'(1) : eff_len;
         trunc_in   = (ctl.load_clear ? 1'b0 : trunc_ff) ||
                      (req_bus.has_char && eff_len == LEN_W'(PATTERN_CAPACITY));
         wg_in      = ctl.word_glob;
         if (ctl.wr_en) begin
            wg_in = !ctl.is_space && (ctl.word_glob || ctl.is_glob_char);
         end
         loading_in = !req_bus.last;
         cand_in    = 1'b0;
      end else if (cand_fire) begin
         loading_in = 1'b0;
         cand_in    = !req_bus.last;
      end
   end

   // Configuration writes
   always_comb begin
      mode_in = mode_ff;
      case_in = case_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         case (mgsm_pkg::csr_index_type'(csr_bus.index))
            mgsm_pkg::CSR_MATCH_MODE:     mode_in = csr_bus.data;
            mgsm_pkg::CSR_CASE_SENSITIVE: case_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   // Output stage: head register plus one skid entry
   assign res_new = cand_fire && req_bus.last;
   assign res     = {&ok_vec, trunc_ff};
   assign pop     = head_v_ff && rsp_bus.ready;

   always_comb begin
      head_v_in = head_v_ff;
      head_in   = head_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (pop) begin
         if (skid_v_ff) begin
            head_in   = skid_ff;
            skid_v_in = res_new;
            skid_in   = res;
         end else begin
            head_v_in = res_new;
            head_in   = res;
         end
      end else if (res_new) begin
         if (head_v_ff) begin
            skid_v_in = 1'b1;
            skid_in   = res;
         end else begin
            head_v_in = 1'b1;
            head_in   = res;
         end
      end
   end

   assign rsp_bus.valid             = head_v_ff;
   assign rsp_bus.matched           = head_ff[1];
   assign rsp_bus.pattern_truncated = head_ff[0];

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         case_ff    <= 1'b0;
         len_ff     <= '0;
         trunc_ff   <= 1'b0;
         wg_ff      <= 1'b0;
         loading_ff <= 1'b0;
         cand_ff    <= 1'b0;
         head_v_ff  <= 1'b0;
         skid_v_ff  <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         case_ff    <= case_in;
         len_ff     <= len_in;
         trunc_ff   <= trunc_in;
         wg_ff      <= wg_in;
         loading_ff <= loading_in;
         cand_ff    <= cand_in;
         head_v_ff  <= head_v_in;
         skid_v_ff  <= skid_v_in;
      end
   end

endmodule

>>> hw/rtl/mgsm_checker.sv
`timescale 1ns / 1ps
module mgsm_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_func,
   input logic req_last,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_matched,
   input logic rsp_pattern_truncated
);

   // Stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_matched) &&
      $stable(rsp_pattern_truncated))
      else $error("stalled result changed");

   // Input is open whenever no result waits
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

   // Final candidate word yields a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func && req_last |=> rsp_valid)
      else $error("missing result");

   // Pattern words never yield a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_func && !rsp_valid |=> !rsp_valid)
      else $error("result from pattern word");

   // Nothing shows right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");

endmodule

bind multiword_glob_substring_matcher mgsm_checker u_mgsm_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_bus.valid),
   .req_ready            (req_bus.ready),
   .req_func             (req_bus.func),
   .req_last             (req_bus.last),
   .rsp_valid            (rsp_bus.valid),
   .rsp_ready            (rsp_bus.ready),
   .rsp_matched          (rsp_bus.matched),
   .rsp_pattern_truncated(rsp_bus.pattern_truncated)
);
